// ===== hdl/umsq_pkg.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI send queue package
// Shared sizes, protocol byte codes and the command and status groups that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package umsq_pkg;

  localparam int QUEUE_SLOTS = 8;
  localparam int SYSEX_DEPTH = 64;

  localparam int QPW = $clog2(QUEUE_SLOTS);
  localparam int SHW = $clog2(SYSEX_DEPTH);
  localparam int SCW = $clog2(SYSEX_DEPTH + 1);

  localparam logic [7:0] CIN_SX_START = 8'h04;
  localparam logic [7:0] SX_BEGIN     = 8'hF0;
  localparam logic [7:0] SX_END       = 8'hF7;

  typedef enum logic [1:0] {
    MODE_ENQUEUE = 2'd0,
    MODE_SYSEX   = 2'd1,
    MODE_POLL    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] key;
    logic [6:0] value;
  } slot_t;

  typedef struct packed {
    logic load_in;
    logic idx_clr;
    logic idx_inc;
    logic q_rd_sel;
    logic slot_wr_idx;
    logic slot_wr_new;
    logic sx_append;
    logic sx_start;
    logic sx_take;
    logic sx_put;
    logic sx_fin;
    logic q_fill;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic idx_last;
    logic sx_pending;
    logic q_nonempty;
    logic take_more;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== hdl/umsq_dp.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI send queue datapath
// Slot memory with valid bits, sysex byte ring, packet assembly registers and
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module umsq_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          in_tdata,
  input  umsq_pkg::cmd_t       cmd,
  output umsq_pkg::stat_t      stat,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata
);
  import umsq_pkg::*;

  logic [7:0]     in_st_r;
  logic [6:0]     in_key_r;
  logic [6:0]     in_val_r;
  logic [6:0]     in_sx_r;

  slot_t          slot_mem [QUEUE_SLOTS];
  logic [QUEUE_SLOTS-1:0] slot_vld_r;
  slot_t          slot_rd_r;
  logic           slot_rd_vld_r;
  logic [QPW-1:0] idx_r;
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW-1:0] q_addr;
  slot_t          slot_cur;
  slot_t          slot_new;

  logic [6:0]     sx_mem [SYSEX_DEPTH];
  logic [6:0]     sx_rd_r;
  logic [SHW-1:0] sx_head_r;
  logic [SCW-1:0] sx_cnt_r;
  logic           sx_started_r;
  logic           sx_end_r;
  logic [SCW:0]   sx_sum;
  logic [SHW-1:0] sx_wa;
  logic [SHW-1:0] sx_head_inc;
  logic [SCW:0]   remain;
  logic           is_end_now;
  logic           sx_room;

  logic [7:0]     pkt_r [4];
  logic [2:0]     pos_r;

  logic           out_valid_r;
  logic [31:0]    out_data_r;

  assign slot_cur   = slot_rd_vld_r ? slot_rd_r : '0;
  assign slot_new   = '{status: in_st_r, key: in_key_r, value: in_val_r};
  assign q_addr     = cmd.q_rd_sel ? rd_ptr_r : idx_r;

  assign sx_sum      = (SCW+1)'(sx_head_r) + (SCW+1)'(sx_cnt_r);
  assign sx_wa       = (sx_sum >= (SCW+1)'(SYSEX_DEPTH)) ?
                       SHW'(sx_sum - (SCW+1)'(SYSEX_DEPTH)) : SHW'(sx_sum);
  assign sx_head_inc = (sx_head_r == SHW'(SYSEX_DEPTH - 1)) ? '0 : sx_head_r + 1'b1;
  assign sx_room     = sx_cnt_r < SCW'(SYSEX_DEPTH);
  // Bytes still to go out in this message, counting the start and end marks.
  assign remain      = (SCW+1)'(sx_cnt_r) + (sx_started_r ? (SCW+1)'(1) : (SCW+1)'(2));
  assign is_end_now  = remain <= (SCW+1)'(3);

  always_comb begin
    stat.match      = (slot_cur.status == in_st_r) && (slot_cur.key == in_key_r);
    stat.idx_last   = idx_r == QPW'(QUEUE_SLOTS - 1);
    stat.sx_pending = (sx_cnt_r != '0) || sx_started_r;
    stat.q_nonempty = wr_ptr_r != rd_ptr_r;
    stat.take_more  = sx_end_r ? ((sx_cnt_r != '0) && (pos_r < 3'd3)) : (pos_r <= 3'd3);
    stat.out_free   = !out_valid_r || out_tready;
  end

  // Input capture and memories: payload only, no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_st_r  <= in_tdata[7:0];
      in_key_r <= in_tdata[14:8];
      in_val_r <= in_tdata[21:15];
      in_sx_r  <= in_tdata[28:22];
    end
    if (cmd.slot_wr_idx) begin
      slot_mem[idx_r] <= slot_new;
    end else if (cmd.slot_wr_new) begin
      slot_mem[wr_ptr_r] <= slot_new;
    end
    slot_rd_r <= slot_mem[q_addr];
    if (cmd.sx_append && sx_room) begin
      sx_mem[sx_wa] <= in_sx_r;
    end
    sx_rd_r <= sx_mem[sx_head_r];
  end

  // Packet assembly registers.
  always_ff @(posedge clk) begin
    if (cmd.q_fill) begin
      pkt_r[0] <= {slot_cur.status[3:0], slot_cur.status[7:4]};
      pkt_r[1] <= slot_cur.status;
      pkt_r[2] <= {1'b0, slot_cur.key};
      pkt_r[3] <= {1'b0, slot_cur.value};
    end else if (cmd.sx_start) begin
      pkt_r[0] <= is_end_now ? CIN_SX_START + 8'(remain) : CIN_SX_START;
      pkt_r[1] <= sx_started_r ? 8'h00 : SX_BEGIN;
      pkt_r[2] <= 8'h00;
      pkt_r[3] <= 8'h00;
    end else if (cmd.sx_put) begin
      pkt_r[pos_r[1:0]] <= {1'b0, sx_rd_r};
    end else if (cmd.sx_fin && sx_end_r) begin
      pkt_r[pos_r[1:0]] <= SX_END;
    end
    if (cmd.out_load) begin
      out_data_r <= {pkt_r[3], pkt_r[2], pkt_r[1], pkt_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r    <= '0;
      slot_rd_vld_r <= 1'b0;
      idx_r         <= '0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      sx_head_r     <= '0;
      sx_cnt_r      <= '0;
      sx_started_r  <= 1'b0;
      sx_end_r      <= 1'b0;
      pos_r         <= 3'd1;
      out_valid_r   <= 1'b0;
    end else begin
      slot_rd_vld_r <= slot_vld_r[q_addr];
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.slot_wr_idx) begin
        slot_vld_r[idx_r] <= 1'b1;
      end else if (cmd.slot_wr_new) begin
        slot_vld_r[wr_ptr_r] <= 1'b1;
        wr_ptr_r <= (wr_ptr_r == QPW'(QUEUE_SLOTS - 1)) ? '0 : wr_ptr_r + 1'b1;
      end else if (cmd.q_fill) begin
        slot_vld_r[rd_ptr_r] <= 1'b0;
        rd_ptr_r <= (rd_ptr_r == QPW'(QUEUE_SLOTS - 1)) ? '0 : rd_ptr_r + 1'b1;
      end

      if (cmd.sx_append && sx_room) begin
        sx_cnt_r <= sx_cnt_r + 1'b1;
      end else if (cmd.sx_start) begin
        sx_started_r <= 1'b1;
        sx_end_r     <= is_end_now;
        pos_r        <= sx_started_r ? 3'd1 : 3'd2;
      end else if (cmd.sx_take) begin
        sx_head_r <= sx_head_inc;
        sx_cnt_r  <= sx_cnt_r - 1'b1;
      end else if (cmd.sx_put) begin
        pos_r <= pos_r + 3'd1;
      end else if (cmd.sx_fin && sx_end_r) begin
        sx_head_r    <= '0;
        sx_cnt_r     <= '0;
        sx_started_r <= 1'b0;
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sx_cnt_r <= SCW'(SYSEX_DEPTH))
    else $error("sysex count beyond buffer depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten while held");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sx_fin && sx_end_r) |=> (sx_cnt_r == '0) && !sx_started_r && (sx_head_r == '0))
    else $error("sysex state not cleared after end packet");

  a_put_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sx_put || (cmd.sx_fin && sx_end_r)) |-> (pos_r >= 3'd1) && (pos_r <= 3'd3))
    else $error("packet byte position out of range");

endmodule

`default_nettype wire

// ===== hdl/umsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI send queue controller
// Sequences the slot search, sysex append, packet assembly and output load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module umsq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  umsq_pkg::mode_t  in_mode,
  input  umsq_pkg::stat_t  stat,
  output umsq_pkg::cmd_t   cmd
);
  import umsq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_APPEND,
    S_POLL,
    S_Q_FILL,
    S_SX_START,
    S_SX_RD,
    S_SX_PUT,
    S_SX_FIN,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_tready_r;
  logic   accept;

  assign accept    = in_tvalid && in_tready_r;
  assign in_tready = in_tready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          cmd.idx_clr = 1'b1;
          unique case (in_mode)
            MODE_ENQUEUE: state_nxt = S_SRCH_RD;
            MODE_SYSEX:   state_nxt = S_APPEND;
            MODE_POLL:    state_nxt = S_POLL;
            MODE_NONE:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.slot_wr_idx = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.idx_last) begin
          cmd.slot_wr_new = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end
      S_APPEND: begin
        cmd.sx_append = 1'b1;
        state_nxt = S_IDLE;
      end
      S_POLL: begin
        cmd.q_rd_sel = 1'b1;
        if (stat.sx_pending) begin
          state_nxt = S_SX_START;
        end else if (stat.q_nonempty) begin
          state_nxt = S_Q_FILL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_FILL: begin
        cmd.q_fill = 1'b1;
        state_nxt = S_OUT;
      end
      S_SX_START: begin
        cmd.sx_start = 1'b1;
        state_nxt = S_SX_RD;
      end
      S_SX_RD: begin
        if (stat.take_more) begin
          cmd.sx_take = 1'b1;
          state_nxt = S_SX_PUT;
        end else begin
          state_nxt = S_SX_FIN;
        end
      end
      S_SX_PUT: begin
        cmd.sx_put = 1'b1;
        state_nxt = S_SX_RD;
      end
      S_SX_FIN: begin
        cmd.sx_fin = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= state_nxt == S_IDLE;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/usb_midi_send_queue_packetizer_core.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI send queue and sysex packetizer
// Queues channel messages, collects sysex bytes and emits one four-byte
// USB-MIDI event packet for each poll that finds something to send.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata / tuser contents
//  in_      slave      tuser: mode; tdata: status, key, value, sysex byte
//  out_     master     tdata: header, byte one, byte two, byte three
//
// Sequence: an item is taken in the idle state. A channel message walks the
// slot memory slot by slot, reading and then comparing each slot; a sysex
// append writes the byte to the sysex ring; a poll builds a packet from a
// queued slot or reads sysex bytes one at a time, each with a read and a put
// state, from the sysex memory.
// Reset: synchronous and active low. Slot valid bits clear at once, so an
// empty slot reads as zero; there is no clearing pass. Sysex memory has no
// reset and only written entries are ever read.
// Stalls: the result sits in an output register; the block keeps taking new
// items while it waits and only holds before loading the next packet.
//
`timescale 1ns / 1ps
`default_nettype none

module usb_midi_send_queue_packetizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: status_byte[7:0], key_byte[14:8], value_byte[21:15],
  // sysex_data[28:22], zero fill [31:29].
  input  logic [31:0] in_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: header[7:0], byte_one[15:8], byte_two[23:16],
  // byte_three[31:24].
  output logic [31:0] out_tdata
);
  import umsq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller sees only the mode and the status group; all message
  // bytes stay in the datapath.
  umsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (mode_t'(in_tuser)),
    .stat      (stat),
    .cmd       (cmd)
  );

  umsq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/sv/usb_midi_send_queue_packetizer_core_checker.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI send queue packetizer checker
// Watches both streams, predicts every packet the block must send and
// compares each sent packet byte by byte with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usb_midi_send_queue_packetizer_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // Fields from bit 0: status_byte[7:0], key_byte[14:8], value_byte[21:15],
  // sysex_data[28:22], zero fill [31:29].
  input  logic [31:0] in_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: header[7:0], byte_one[15:8], byte_two[23:16],
  // byte_three[31:24].
  input  logic [31:0] out_tdata,
  output int          fail_count,
  output int          expected_count
);
  import umsq_pkg::*;

  typedef struct packed {
    logic [7:0] byte_three;
    logic [7:0] byte_two;
    logic [7:0] byte_one;
    logic [7:0] header;
  } usb_packet_t;

  // Shadow copy of the queue and the sysex ring.
  logic [7:0]     slot_status [QUEUE_SLOTS];
  logic [6:0]     slot_key    [QUEUE_SLOTS];
  logic [6:0]     slot_value  [QUEUE_SLOTS];
  logic [QPW-1:0] wr_slot;
  logic [QPW-1:0] rd_slot;
  logic [6:0]     sx_mem [SYSEX_DEPTH];
  logic [SHW-1:0] sx_head;
  logic [SCW-1:0] sx_count;
  logic           sx_started;

  usb_packet_t expected_packets[$];

  function automatic logic [7:0] pop_sysex_byte();
    logic [7:0] b;
    b = {1'b0, sx_mem[sx_head]};
    sx_head = sx_head + 1'b1;
    if (sx_count != 0) sx_count = sx_count - 1'b1;
    return b;
  endfunction

  task automatic queue_message(input logic [7:0] st, input logic [6:0] key,
                               input logic [6:0] val);
    bit hit;
    hit = 1'b0;
    // The search covers every slot, cleared ones included.
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      if (!hit && slot_status[i] == st && slot_key[i] == key) begin
        slot_value[i] = val;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      slot_status[wr_slot] = st;
      slot_key[wr_slot]    = key;
      slot_value[wr_slot]  = val;
      wr_slot = wr_slot + 1'b1;
    end
  endtask

  function automatic bit build_packet(output usb_packet_t pkt);
    logic [7:0] b [4];
    logic [7:0] st;
    int         remain;
    int         k;
    pkt = '0;
    for (int i = 0; i < 4; i++) b[i] = 8'h00;
    if (sx_count != 0 || sx_started) begin
      remain = int'(sx_count) + 1 + (sx_started ? 0 : 1);
      if (remain > 3) begin
        b[0] = CIN_SX_START;
        if (!sx_started) begin
          b[1] = SX_BEGIN;
          sx_started = 1'b1;
        end else begin
          b[1] = pop_sysex_byte();
        end
        b[2] = pop_sysex_byte();
        b[3] = pop_sysex_byte();
      end else begin
        // End packet: code index tells how many of the three bytes count.
        k = 1;
        b[0] = CIN_SX_START + 8'(remain);
        if (!sx_started) begin
          b[k] = SX_BEGIN;
          k++;
        end
        while (sx_count != 0 && k < 3) begin
          b[k] = pop_sysex_byte();
          k++;
        end
        b[k] = SX_END;
        sx_started = 1'b0;
        sx_count   = '0;
        sx_head    = '0;
      end
      pkt = {b[3], b[2], b[1], b[0]};
      return 1'b1;
    end
    if (wr_slot != rd_slot) begin
      st = slot_status[rd_slot];
      pkt.header     = {st[3:0], st[7:4]};
      pkt.byte_one   = st;
      pkt.byte_two   = {1'b0, slot_key[rd_slot]};
      pkt.byte_three = {1'b0, slot_value[rd_slot]};
      slot_status[rd_slot] = '0;
      slot_key[rd_slot]    = '0;
      slot_value[rd_slot]  = '0;
      rd_slot = rd_slot + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_packet(input logic [1:0] mode, input logic [31:0] d);
    usb_packet_t    pkt;
    logic [SHW-1:0] wr_pos;
    case (mode_t'(mode))
      MODE_ENQUEUE: queue_message(d[7:0], d[14:8], d[21:15]);
      MODE_SYSEX: begin
        // A byte arriving into a full ring is dropped.
        if (sx_count < SYSEX_DEPTH) begin
          wr_pos = sx_head + sx_count[SHW-1:0];
          sx_mem[wr_pos] = d[28:22];
          sx_count = sx_count + 1'b1;
        end
      end
      MODE_POLL: begin
        if (build_packet(pkt)) expected_packets.push_back(pkt);
      end
      default: ;
    endcase
  endtask

  task automatic check_byte(input string name, input logic [7:0] want,
                            input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, actual %02h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    usb_packet_t want;
    usb_packet_t got;
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        slot_status[i] = '0;
        slot_key[i]    = '0;
        slot_value[i]  = '0;
      end
      for (int i = 0; i < SYSEX_DEPTH; i++) sx_mem[i] = '0;
      wr_slot    = '0;
      rd_slot    = '0;
      sx_head    = '0;
      sx_count   = '0;
      sx_started = 1'b0;
      expected_packets.delete();
      fail_count = 0;
    end else begin
      // Results first, so an item taken at this same edge cannot hide a
      // packet that arrived with nothing expected.
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_packets.size() == 0) begin
          $error("packet %08h sent with nothing expected", out_tdata);
          fail_count++;
        end else begin
          want = expected_packets.pop_front();
          check_byte("header", want.header, got.header);
          check_byte("byte_one", want.byte_one, got.byte_one);
          check_byte("byte_two", want.byte_two, got.byte_two);
          check_byte("byte_three", want.byte_three, got.byte_three);
        end
      end
      if (in_tvalid && in_tready) predict_packet(in_tuser, in_tdata);
    end
    expected_count = expected_packets.size();
  end

endmodule

// ===== tb/sv/usb_midi_send_queue_packetizer_core_tb.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI send queue packetizer testbench
// Drives channel messages, sysex bytes and endpoint polls into the block,
// with random gaps on both streams, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usb_midi_send_queue_packetizer_core_tb;
  import umsq_pkg::*;

  // Roughly how many items the run sends in total.
  localparam int ITEM_TARGET    = 1050;
  // The tail wait and the watchdog both outlast the longest operation of the
  // block.
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PERCENT   = 17;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // Fields from bit 0: status_byte[7:0], key_byte[14:8], value_byte[21:15],
  // sysex_data[28:22], zero fill [31:29].
  logic [31:0] in_tdata;
  // Fields from bit 0: mode[1:0].
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // Fields from bit 0: header[7:0], byte_one[15:8], byte_two[23:16],
  // byte_three[31:24].
  logic [31:0] out_tdata;

  int fail_count;
  int expected_count;
  int items_sent;
  int quiet_cycles;
  // When low, neither side inserts gaps.
  bit idle_on;

  usb_midi_send_queue_packetizer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  usb_midi_send_queue_packetizer_core_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .expected_count (expected_count)
  );

  // 4 ns clock.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls at random, changing its ready at the falling edge.
  always @(negedge clk) begin
    out_tready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
  end

  // The watchdog counts cycles in which neither stream moves an item; a
  // correct run never comes near the limit, so reaching it means a hang.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("usb_midi_send_queue_packetizer_core_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and holds it until the block takes it. A gap lowers
  // valid only at a falling edge where no new item is offered.
  task automatic send_item(input mode_t mode, input logic [31:0] data);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_message(input logic [7:0] st, input logic [6:0] key,
                              input logic [6:0] val);
    send_item(MODE_ENQUEUE, {3'b000, 7'h00, val, key, st});
  endtask

  task automatic send_sysex(input logic [6:0] b);
    send_item(MODE_SYSEX, {3'b000, b, 22'h0});
  endtask

  task automatic send_poll();
    send_item(MODE_POLL, 32'h0);
  endtask

  // The sender holds off until every predicted packet has gone out.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_count != 0) @(negedge clk);
  endtask

  // Nearly half the time a status with low nibble zero or one so messages often hit a
  // queued slot; now and then a zero status that can match a cleared slot.
  function automatic logic [7:0] pick_status();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r < 10) return {4'h8 | 4'($urandom_range(0, 7)), 4'($urandom_range(0, 1))};
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [6:0] pick_key();
    if ($urandom_range(0, 1) == 0) return 7'($urandom_range(0, 3));
    return 7'($urandom_range(0, 127));
  endfunction

  initial begin
    int n;
    int len;
    int scenario;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_NONE;
    out_tready = 1'b0;
    items_sent = 0;
    idle_on    = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A poll with nothing pending, and an ignored mode.
    send_poll();
    send_item(MODE_NONE, 32'h1FFF_FFFF);
    // Field extremes, then a repeat of status and key that only updates.
    send_message(8'h80, 7'h00, 7'h00);
    send_message(8'hFF, 7'h7F, 7'h7F);
    send_message(8'h90, 7'd60, 7'd100);
    send_message(8'h90, 7'd60, 7'd1);
    // Zero status and key land on a cleared slot and never go out.
    send_message(8'h00, 7'h00, 7'd5);
    send_poll();
    send_poll();
    send_poll();
    send_poll();
    // Sysex of one byte, then of two bytes.
    send_sysex(7'h7F);
    send_poll();
    send_sysex(7'h00);
    send_sysex(7'h55);
    send_poll();
    send_poll();
    // Sysex wins over a queued message; a byte added mid-message extends it.
    send_sysex(7'h11);
    send_sysex(7'h22);
    send_sysex(7'h33);
    send_message(8'hB0, 7'd7, 7'd64);
    send_poll();
    send_sysex(7'h44);
    send_poll();
    send_poll();
    send_poll();
    drain_results();

    // Random part: bursts of messages, framed sysex runs and noise.
    while (items_sent < ITEM_TARGET) begin
      idle_on  = !(items_sent >= 350 && items_sent < 550);
      scenario = $urandom_range(0, 19);
      if (scenario < 8) begin
        // Up to eleven messages can wrap the ring and overwrite slots.
        n = $urandom_range(1, 11);
        for (int j = 0; j < n; j++) send_message(pick_status(), pick_key(), 7'($urandom));
        n = $urandom_range(0, n + 1);
        for (int j = 0; j < n; j++) send_poll();
      end else if (scenario < 14) begin
        // Long runs fill the sysex ring and drop the bytes beyond it.
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 8);
        for (int j = 0; j < len; j++) send_sysex(7'($urandom));
        n = (len + 4) / 3 + $urandom_range(0, 2);
        for (int j = 0; j < n; j++) begin
          case ($urandom_range(0, 7))
            0: send_sysex(7'($urandom));
            1: send_message(pick_status(), pick_key(), 7'($urandom));
            default: ;
          endcase
          send_poll();
        end
      end else if (scenario < 18) begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) send_item(mode_t'(2'($urandom)), {3'b000, 29'($urandom)});
      end else if (scenario == 18) begin
        drain_results();
      end else begin
        n = $urandom_range(1, 4);
        for (int j = 0; j < n; j++) send_poll();
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("usb_midi_send_queue_packetizer_core_tb passed");
    end else begin
      $display("usb_midi_send_queue_packetizer_core_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/umsq_pkg.sv
hdl/umsq_dp.sv
hdl/umsq_ctrl.sv
hdl/usb_midi_send_queue_packetizer_core.sv
tb/sv/usb_midi_send_queue_packetizer_core_checker.sv
tb/sv/usb_midi_send_queue_packetizer_core_tb.sv
